[rtl/ale_pkg.sv]
`default_nettype none
package ale_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int ACTION_W  = 3;
   localparam int POS_W     = 7;
   localparam int CODE_W    = 32;
   localparam int AGE_W     = 8;
   localparam int STATUS_W  = 3;
   localparam int FIDX_W    = 6;
   localparam int COUNT_W   = 7;
   localparam int ENTRY_W   = CODE_W + AGE_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 3'd0,
      ACT_APPEND = 3'd1,
      ACT_FRONT  = 3'd2,
      ACT_INSERT = 3'd3,
      ACT_REMOVE = 3'd4,
      ACT_SEARCH = 3'd5,
      ACT_DUMP   = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

endpackage
`default_nettype wire

[rtl/ale_if.sv]
`default_nettype none
interface ale_req_if;
   logic                                valid;
   logic                                ready;
   logic [ale_pkg::ACTION_W-1:0]        action;
   logic [ale_pkg::POS_W-1:0]           position;
   logic signed [ale_pkg::CODE_W-1:0]   entry_code;
   logic [ale_pkg::AGE_W-1:0]           entry_age;

   modport source (output valid, action, position, entry_code, entry_age, input ready);
   modport sink (input valid, action, position, entry_code, entry_age, output ready);
endinterface

interface ale_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ale_pkg::STATUS_W-1:0]        status;
   logic [ale_pkg::FIDX_W-1:0]          found_index;
   logic signed [ale_pkg::CODE_W-1:0]   found_code;
   logic [ale_pkg::AGE_W-1:0]           found_age;
   logic [ale_pkg::COUNT_W-1:0]         entry_count;
   logic                                last_result;

   modport source (output valid, status, found_index, found_code, found_age, entry_count,
                   last_result, input ready);
   modport sink (input valid, status, found_index, found_code, found_age, entry_count,
                 last_result, output ready);
endinterface
`default_nettype wire

[rtl/array_list_engine_unit.sv]
`default_nettype none
// Ordered list of up to CAPACITY entries (code and age) held in one single-port-write RAM.
// The block takes one word at a time and is not ready until its last result word is
// loaded into the output register. Every move of an entry is a RAM read followed by a
// write: insert at position p moves the entries from p to the tail down by one place,
// remove at p moves the entries after p up by one, search reads entries from index zero
// until a code matches or the list ends, and a dump reads and emits every entry in order.
// Clear, errors and unknown actions give only a status word.
// The output register lets the next word be taken while the previous result still waits.
module array_list_engine_unit #(
   parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ale_req_if.sink    req_if,
   ale_rsp_if.source  rsp_if
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int ADR_W = $clog2(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_WR,
      S_PUT,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   ale_pkg::action_type           act_ff, act_in;
   logic [CNT_W-1:0]              pos_ff, pos_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [ale_pkg::CODE_W-1:0]    code_ff, code_in;
   logic [ale_pkg::AGE_W-1:0]     age_ff, age_in;
   ale_pkg::status_type           stat_ff, stat_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ale_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ale_pkg::FIDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [ale_pkg::CODE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic [ale_pkg::AGE_W-1:0]     rsp_age_ff, rsp_age_in;
   logic [ale_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          ram_we, ram_re;
   logic [ADR_W-1:0]              ram_waddr, ram_raddr;
   logic [ale_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
   logic [ale_pkg::CODE_W-1:0]    rd_code;
   logic [ale_pkg::AGE_W-1:0]     rd_age;

   logic                          accept, emit_ok, last_entry;
   logic [ale_pkg::POS_W-1:0]     put_pos, count7, cap7;
   logic [CNT_W:0]                idx_p1, idx_p2;

   ale_ram #(
      .WIDTH (ale_pkg::ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_code = ram_rdata[ale_pkg::ENTRY_W-1:ale_pkg::AGE_W];
   assign rd_age  = ram_rdata[ale_pkg::AGE_W-1:0];

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign emit_ok      = !rsp_valid_ff || rsp_if.ready;

   assign count7     = ale_pkg::POS_W'(count_ff);
   assign cap7       = ale_pkg::POS_W'(CAPACITY);
   assign idx_p1     = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(1);
   assign idx_p2     = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(2);
   assign last_entry = (idx_p1 == (CNT_W + 1)'(count_ff));

   always_comb begin
      case (ale_pkg::action_type'(req_if.action))
         ale_pkg::ACT_APPEND: put_pos = count7;
         ale_pkg::ACT_FRONT:  put_pos = '0;
         default:             put_pos = req_if.position;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      code_in  = code_ff;
      age_in   = age_ff;
      stat_in  = stat_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_age_in    = rsp_age_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = idx_ff[ADR_W-1:0];
      ram_raddr = idx_ff[ADR_W-1:0];
      ram_wdata = ram_rdata;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in  = ale_pkg::action_type'(req_if.action);
               code_in = req_if.entry_code;
               age_in  = req_if.entry_age;
               stat_in = ale_pkg::ST_OK;
               state_in = S_DONE;
               case (ale_pkg::action_type'(req_if.action))
                  ale_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ale_pkg::ACT_APPEND, ale_pkg::ACT_FRONT, ale_pkg::ACT_INSERT: begin
                     if (count7 == cap7) begin
                        stat_in = ale_pkg::ST_FULL;
                     end else if (put_pos > count7) begin
                        stat_in = ale_pkg::ST_BADPOS;
                     end else begin
                        pos_in = put_pos[CNT_W-1:0];
                        idx_in = count_ff;
                        if (count7 > put_pos) begin
                           state_in = S_RD;
                        end else begin
                           state_in = S_PUT;
                        end
                     end
                  end
                  ale_pkg::ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        stat_in = ale_pkg::ST_EMPTY;
                     end else if (req_if.position >= count7) begin
                        stat_in = ale_pkg::ST_BADPOS;
                     end else begin
                        idx_in = req_if.position[CNT_W-1:0];
                        if (req_if.position + ale_pkg::POS_W'(1) < count7) begin
                           state_in = S_RD;
                        end else begin
                           count_in = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  ale_pkg::ACT_SEARCH, ale_pkg::ACT_DUMP: begin
                     if (count_ff == '0) begin
                        stat_in = ale_pkg::ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_RD: begin
            ram_re = 1'b1;
            case (act_ff)
               ale_pkg::ACT_APPEND, ale_pkg::ACT_FRONT, ale_pkg::ACT_INSERT: begin
                  ram_raddr = ADR_W'(idx_ff - CNT_W'(1));
                  state_in  = S_WR;
               end
               ale_pkg::ACT_REMOVE: begin
                  ram_raddr = ADR_W'(idx_p1);
                  state_in  = S_WR;
               end
               default: begin
                  state_in = S_SCAN;
               end
            endcase
         end

         S_WR: begin
            // The entry read in the previous cycle moves one place over.
            ram_we = 1'b1;
            if (act_ff == ale_pkg::ACT_REMOVE) begin
               idx_in = idx_p1[CNT_W-1:0];
               if (idx_p2 < (CNT_W + 1)'(count_ff)) begin
                  state_in = S_RD;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  stat_in  = ale_pkg::ST_OK;
                  state_in = S_DONE;
               end
            end else begin
               idx_in = idx_ff - CNT_W'(1);
               if (idx_ff - CNT_W'(1) > pos_ff) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_PUT;
               end
            end
         end

         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[ADR_W-1:0];
            ram_wdata = {code_ff, age_ff};
            count_in  = count_ff + CNT_W'(1);
            stat_in   = ale_pkg::ST_OK;
            state_in  = S_DONE;
         end

         S_SCAN: begin
            if (act_ff == ale_pkg::ACT_SEARCH && rd_code != code_ff) begin
               if (last_entry) begin
                  stat_in  = ale_pkg::ST_NOTFOUND;
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_p1[CNT_W-1:0];
                  state_in = S_RD;
               end
            end else if (emit_ok) begin
               // A search hit or one dump word; the read data holds while stalled.
               rsp_valid_in  = 1'b1;
               rsp_status_in = ale_pkg::ST_OK;
               rsp_index_in  = ale_pkg::FIDX_W'(idx_ff);
               rsp_code_in   = rd_code;
               rsp_age_in    = rd_age;
               rsp_count_in  = ale_pkg::COUNT_W'(count_ff);
               if (act_ff == ale_pkg::ACT_SEARCH || last_entry) begin
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  rsp_last_in = 1'b0;
                  idx_in      = idx_p1[CNT_W-1:0];
                  state_in    = S_RD;
               end
            end
         end

         S_DONE: begin
            if (emit_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_index_in  = '0;
               rsp_code_in   = '0;
               rsp_age_in    = '0;
               rsp_count_in  = ale_pkg::COUNT_W'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      code_ff       <= code_in;
      age_ff        <= age_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_age_ff    <= rsp_age_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.found_index = rsp_index_ff;
   assign rsp_if.found_code  = rsp_code_ff;
   assign rsp_if.found_age   = rsp_age_ff;
   assign rsp_if.entry_count = rsp_count_ff;
   assign rsp_if.last_result = rsp_last_ff;

endmodule
`default_nettype wire

[rtl/ale_ram.sv]
`default_nettype none
module ale_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire
